/* src/rsi_pkg.sv */
// Shared widths, constants, status codes and sideband types for the ray-sphere pipeline.
package rsi_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int CW    = COORD_WIDTH;
    localparam int OC_W  = CW + 1;          // origin minus center
    localparam int PD_W  = 2 * CW;          // d*d
    localparam int DOC_W = 2 * CW + 1;      // d*oc
    localparam int OO_W  = 2 * CW + 2;      // oc*oc
    localparam int RR_W  = 2 * (CW - 1);    // r*r
    localparam int A_W   = 2 * CW;          // a, unsigned
    localparam int H_W   = 2 * CW + 2;      // half of b, signed
    localparam int HM_W  = 2 * CW + 1;      // |h|
    localparam int C_W   = 2 * CW + 3;      // c, signed
    localparam int CM_W  = 2 * CW + 2;      // |c|

    localparam int HL_W  = HM_W / 2;
    localparam int HH_W  = HM_W - HL_W;
    localparam int AL_W  = A_W / 2;
    localparam int AH_W  = A_W - AL_W;
    localparam int CL_W  = CM_W / 2;
    localparam int CH_W  = CM_W - CL_W;
    localparam int H2_W  = 2 * HM_W;
    localparam int AC_W  = A_W + CM_W;

    localparam int D_W   = 4 * CW + 4;      // h*h - a*c, signed
    localparam int SQ_W  = 2 * CW + 3;      // square root width
    localparam int RAD_W = 2 * SQ_W;        // radicand width
    localparam int SR_W  = SQ_W + 2;        // square root partial remainder

    localparam int NUM_W = 2 * CW + 5;      // -b +/- s, signed
    localparam int NM_W  = 2 * CW + 4;      // magnitude of the numerator
    localparam int M_W   = NM_W + FRAC_BITS;
    localparam int DV_W  = A_W + 1;         // divisor 2a
    localparam int Q_W   = CW - 1;          // quotient bits below saturation
    localparam int CMP_W = (M_W > DV_W + Q_W) ? M_W : DV_W + Q_W;

    localparam logic [63:0] MAX64    = (64'd1 << (CW - 1)) - 64'd1;
    localparam logic [63:0] FAR_FULL = 64'd20000 << FRAC_BITS;
    localparam logic [CW-1:0] MAX_DIST = CW'(MAX64);
    localparam logic [CW-1:0] FAR_DIST = (FAR_FULL > MAX64) ? CW'(MAX64) : CW'(FAR_FULL);

    localparam logic [1:0] ST_HIT    = 2'd0;
    localparam logic [1:0] ST_NOROOT = 2'd1;
    localparam logic [1:0] ST_BEHIND = 2'd2;

    typedef struct packed {
        logic [H_W-1:0] h;
        logic [A_W-1:0] a;
        logic [CW-1:0]  fallback;
        logic           noroot;
        logic           zero_a;
    } sq_side_t;

    typedef struct packed {
        logic [CW-1:0] fallback;
        logic          noroot;
        logic          zero_a;
        logic          sel_neg;
        logic          ovf;
    } dv_side_t;

endpackage

/* src/rsi_if.sv */
// Request and response channel interfaces of the ray-sphere block.
interface rsi_req_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [rsi_pkg::COORD_WIDTH-1:0] origin_x;
    logic signed [rsi_pkg::COORD_WIDTH-1:0] origin_y;
    logic signed [rsi_pkg::COORD_WIDTH-1:0] origin_z;
    logic signed [rsi_pkg::COORD_WIDTH-1:0] dir_x;
    logic signed [rsi_pkg::COORD_WIDTH-1:0] dir_y;
    logic signed [rsi_pkg::COORD_WIDTH-1:0] dir_z;
    logic signed [rsi_pkg::COORD_WIDTH-1:0] center_x;
    logic signed [rsi_pkg::COORD_WIDTH-1:0] center_y;
    logic signed [rsi_pkg::COORD_WIDTH-1:0] center_z;
    logic        [rsi_pkg::COORD_WIDTH-2:0] sphere_radius;
    logic signed [rsi_pkg::COORD_WIDTH-1:0] fallback_distance;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, sphere_radius, fallback_distance,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               center_x, center_y, center_z, sphere_radius, fallback_distance,
        output ready
    );
endinterface

interface rsi_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [rsi_pkg::COORD_WIDTH-1:0] hit_distance;
    logic        [1:0]                      hit_status;

    modport source (output valid, hit_distance, hit_status, input ready);
    modport sink (input valid, hit_distance, hit_status, output ready);
endinterface

/* src/ray_sphere_intersect.sv */
// Ray-sphere intersection: quadratic setup, exact discriminant, square root, root division.
// The pipeline runs from request beat to response beat through seven setup stages, one stage
//   per square root bit, three root stages, one stage per quotient bit below saturation,
//   and the output register.
// Throughput: one beat per cycle; the whole pipeline holds while a response waits.
// Reset clears every stage valid bit and the output valid; data registers are not reset.
module ray_sphere_intersect (
    input  logic      clk,
    input  logic      rst_n,
    rsi_req_if.sink   req,
    rsi_rsp_if.source rsp
);

    logic en;

    // Stage 1: operands and origin minus center.
    logic                                 s1_v_reg;
    logic signed [rsi_pkg::CW-1:0]        s1_d_reg  [3];
    logic signed [rsi_pkg::OC_W-1:0]      s1_oc_reg [3];
    logic        [rsi_pkg::CW-2:0]        s1_r_reg;
    logic        [rsi_pkg::CW-1:0]        s1_fb_reg;
    // Stage 2: products.
    logic                                 s2_v_reg;
    logic signed [rsi_pkg::PD_W-1:0]      s2_dd_reg  [3];
    logic signed [rsi_pkg::DOC_W-1:0]     s2_doc_reg [3];
    logic signed [rsi_pkg::OO_W-1:0]      s2_oo_reg  [3];
    logic        [rsi_pkg::RR_W-1:0]      s2_rr_reg;
    logic        [rsi_pkg::CW-1:0]        s2_fb_reg;
    // Stage 3: a, h, c.
    logic                                 s3_v_reg;
    logic        [rsi_pkg::A_W-1:0]       s3_a_reg;
    logic signed [rsi_pkg::H_W-1:0]       s3_h_reg;
    logic signed [rsi_pkg::C_W-1:0]       s3_c_reg;
    logic        [rsi_pkg::CW-1:0]        s3_fb_reg;
    // Stage 4: magnitudes.
    logic                                 s4_v_reg;
    logic        [rsi_pkg::A_W-1:0]       s4_a_reg;
    logic        [rsi_pkg::H_W-1:0]       s4_h_reg;
    logic        [rsi_pkg::HM_W-1:0]      s4_hm_reg;
    logic        [rsi_pkg::CM_W-1:0]      s4_cm_reg;
    logic                                 s4_cneg_reg;
    logic                                 s4_za_reg;
    logic        [rsi_pkg::CW-1:0]        s4_fb_reg;
    // Stage 5: partial products of h*h and a*c.
    logic                                 s5_v_reg;
    logic        [2*rsi_pkg::HL_W-1:0]           s5_hll_reg;
    logic        [rsi_pkg::HH_W+rsi_pkg::HL_W-1:0] s5_hhl_reg;
    logic        [2*rsi_pkg::HH_W-1:0]           s5_hhh_reg;
    logic        [rsi_pkg::AL_W+rsi_pkg::CL_W-1:0] s5_alcl_reg;
    logic        [rsi_pkg::AL_W+rsi_pkg::CH_W-1:0] s5_alch_reg;
    logic        [rsi_pkg::AH_W+rsi_pkg::CL_W-1:0] s5_ahcl_reg;
    logic        [rsi_pkg::AH_W+rsi_pkg::CH_W-1:0] s5_ahch_reg;
    logic        [rsi_pkg::A_W-1:0]       s5_a_reg;
    logic        [rsi_pkg::H_W-1:0]       s5_h_reg;
    logic                                 s5_cneg_reg;
    logic                                 s5_za_reg;
    logic        [rsi_pkg::CW-1:0]        s5_fb_reg;
    // Stage 6: h*h and |a*c|.
    logic                                 s6_v_reg;
    logic        [rsi_pkg::H2_W-1:0]      s6_h2_reg;
    logic        [rsi_pkg::AC_W-1:0]      s6_ac_reg;
    logic        [rsi_pkg::A_W-1:0]       s6_a_reg;
    logic        [rsi_pkg::H_W-1:0]       s6_h_reg;
    logic                                 s6_cneg_reg;
    logic                                 s6_za_reg;
    logic        [rsi_pkg::CW-1:0]        s6_fb_reg;
    // Stage 7: quarter discriminant.
    logic                                 s7_v_reg;
    logic        [rsi_pkg::D_W-1:0]       s7_dq_reg;
    logic        [rsi_pkg::A_W-1:0]       s7_a_reg;
    logic        [rsi_pkg::H_W-1:0]       s7_h_reg;
    logic                                 s7_za_reg;
    logic        [rsi_pkg::CW-1:0]        s7_fb_reg;

    // Square root unit.
    rsi_pkg::sq_side_t                    sq_in_side;
    logic        [rsi_pkg::RAD_W-1:0]     sq_rad;
    logic                                 sq_v;
    logic        [rsi_pkg::SQ_W-1:0]      sq_root;
    rsi_pkg::sq_side_t                    sq_side;

    // Stage 8: numerators.
    logic                                 s8_v_reg;
    logic        [rsi_pkg::NUM_W-1:0]     s8_nn_reg;
    logic        [rsi_pkg::NUM_W-1:0]     s8_nf_reg;
    logic        [rsi_pkg::A_W-1:0]       s8_a_reg;
    logic                                 s8_nr_reg;
    logic                                 s8_za_reg;
    logic        [rsi_pkg::CW-1:0]        s8_fb_reg;
    // Stage 9: numerator magnitudes.
    logic                                 s9_v_reg;
    logic        [rsi_pkg::NM_W-1:0]      s9_mn_reg;
    logic        [rsi_pkg::NM_W-1:0]      s9_mf_reg;
    logic                                 s9_sn_reg;
    logic                                 s9_sf_reg;
    logic        [rsi_pkg::DV_W-1:0]      s9_div_reg;
    logic                                 s9_nr_reg;
    logic                                 s9_za_reg;
    logic        [rsi_pkg::CW-1:0]        s9_fb_reg;
    // Stage 10: root selection.
    logic                                 s10_v_reg;
    logic        [rsi_pkg::NM_W-1:0]      s10_m_reg;
    logic                                 s10_neg_reg;
    logic        [rsi_pkg::DV_W-1:0]      s10_div_reg;
    logic                                 s10_nr_reg;
    logic                                 s10_za_reg;
    logic        [rsi_pkg::CW-1:0]        s10_fb_reg;

    // Divider.
    logic        [rsi_pkg::M_W-1:0]       dv_m;
    logic        [rsi_pkg::DV_W-1:0]      dv_rem;
    rsi_pkg::dv_side_t                    dv_in_side;
    logic                                 dv_v;
    logic        [rsi_pkg::Q_W-1:0]       dv_quo;
    rsi_pkg::dv_side_t                    dv_side;

    // Output register.
    logic                                 out_v_reg;
    logic        [rsi_pkg::CW-1:0]        out_dist_reg;
    logic        [1:0]                    out_st_reg;
    logic        [rsi_pkg::CW-1:0]        out_dist_next;
    logic        [1:0]                    out_st_next;

    logic signed [rsi_pkg::CW-1:0]        in_d  [3];
    logic signed [rsi_pkg::CW-1:0]        in_o  [3];
    logic signed [rsi_pkg::CW-1:0]        in_c  [3];
    logic signed [rsi_pkg::NUM_W-1:0]     two_h;
    logic                                 near_neg;

    assign en        = !out_v_reg || rsp.ready;
    assign req.ready = en;

    assign in_d[0] = req.dir_x;
    assign in_d[1] = req.dir_y;
    assign in_d[2] = req.dir_z;
    assign in_o[0] = req.origin_x;
    assign in_o[1] = req.origin_y;
    assign in_o[2] = req.origin_z;
    assign in_c[0] = req.center_x;
    assign in_c[1] = req.center_y;
    assign in_c[2] = req.center_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg  <= req.valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= s4_v_reg;
            s6_v_reg  <= s5_v_reg;
            s7_v_reg  <= s6_v_reg;
            s8_v_reg  <= sq_v;
            s9_v_reg  <= s8_v_reg;
            s10_v_reg <= s9_v_reg;
            out_v_reg <= dv_v;
        end
    end

    // Setup stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_d_reg[k]  <= in_d[k];
                s1_oc_reg[k] <= rsi_pkg::OC_W'(in_o[k]) - rsi_pkg::OC_W'(in_c[k]);
                s2_dd_reg[k]  <= rsi_pkg::PD_W'(s1_d_reg[k]) * rsi_pkg::PD_W'(s1_d_reg[k]);
                s2_doc_reg[k] <= rsi_pkg::DOC_W'(s1_d_reg[k]) * rsi_pkg::DOC_W'(s1_oc_reg[k]);
                s2_oo_reg[k]  <= rsi_pkg::OO_W'(s1_oc_reg[k]) * rsi_pkg::OO_W'(s1_oc_reg[k]);
            end
            s1_r_reg  <= req.sphere_radius;
            s1_fb_reg <= req.fallback_distance;

            s2_rr_reg <= rsi_pkg::RR_W'(s1_r_reg) * rsi_pkg::RR_W'(s1_r_reg);
            s2_fb_reg <= s1_fb_reg;

            s3_a_reg  <= $unsigned(s2_dd_reg[0]) + $unsigned(s2_dd_reg[1])
                       + $unsigned(s2_dd_reg[2]);
            s3_h_reg  <= rsi_pkg::H_W'(s2_doc_reg[0]) + rsi_pkg::H_W'(s2_doc_reg[1])
                       + rsi_pkg::H_W'(s2_doc_reg[2]);
            s3_c_reg  <= rsi_pkg::C_W'(s2_oo_reg[0]) + rsi_pkg::C_W'(s2_oo_reg[1])
                       + rsi_pkg::C_W'(s2_oo_reg[2]) - rsi_pkg::C_W'(s2_rr_reg);
            s3_fb_reg <= s2_fb_reg;

            s4_a_reg    <= s3_a_reg;
            s4_h_reg    <= s3_h_reg;
            s4_hm_reg   <= rsi_pkg::HM_W'(s3_h_reg[rsi_pkg::H_W-1] ? -s3_h_reg : s3_h_reg);
            s4_cm_reg   <= rsi_pkg::CM_W'(s3_c_reg[rsi_pkg::C_W-1] ? -s3_c_reg : s3_c_reg);
            s4_cneg_reg <= s3_c_reg[rsi_pkg::C_W-1];
            s4_za_reg   <= (s3_a_reg == '0);
            s4_fb_reg   <= s3_fb_reg;

            // Both wide products are split into halves of about a word each.
            s5_hll_reg  <= (2*rsi_pkg::HL_W)'(s4_hm_reg[rsi_pkg::HL_W-1:0])
                         * (2*rsi_pkg::HL_W)'(s4_hm_reg[rsi_pkg::HL_W-1:0]);
            s5_hhl_reg  <= (rsi_pkg::HH_W+rsi_pkg::HL_W)'(s4_hm_reg[rsi_pkg::HM_W-1:rsi_pkg::HL_W])
                         * (rsi_pkg::HH_W+rsi_pkg::HL_W)'(s4_hm_reg[rsi_pkg::HL_W-1:0]);
            s5_hhh_reg  <= (2*rsi_pkg::HH_W)'(s4_hm_reg[rsi_pkg::HM_W-1:rsi_pkg::HL_W])
                         * (2*rsi_pkg::HH_W)'(s4_hm_reg[rsi_pkg::HM_W-1:rsi_pkg::HL_W]);
            s5_alcl_reg <= (rsi_pkg::AL_W+rsi_pkg::CL_W)'(s4_a_reg[rsi_pkg::AL_W-1:0])
                         * (rsi_pkg::AL_W+rsi_pkg::CL_W)'(s4_cm_reg[rsi_pkg::CL_W-1:0]);
            s5_alch_reg <= (rsi_pkg::AL_W+rsi_pkg::CH_W)'(s4_a_reg[rsi_pkg::AL_W-1:0])
                         * (rsi_pkg::AL_W+rsi_pkg::CH_W)'(s4_cm_reg[rsi_pkg::CM_W-1:rsi_pkg::CL_W]);
            s5_ahcl_reg <= (rsi_pkg::AH_W+rsi_pkg::CL_W)'(s4_a_reg[rsi_pkg::A_W-1:rsi_pkg::AL_W])
                         * (rsi_pkg::AH_W+rsi_pkg::CL_W)'(s4_cm_reg[rsi_pkg::CL_W-1:0]);
            s5_ahch_reg <= (rsi_pkg::AH_W+rsi_pkg::CH_W)'(s4_a_reg[rsi_pkg::A_W-1:rsi_pkg::AL_W])
                         * (rsi_pkg::AH_W+rsi_pkg::CH_W)'(s4_cm_reg[rsi_pkg::CM_W-1:rsi_pkg::CL_W]);
            s5_a_reg    <= s4_a_reg;
            s5_h_reg    <= s4_h_reg;
            s5_cneg_reg <= s4_cneg_reg;
            s5_za_reg   <= s4_za_reg;
            s5_fb_reg   <= s4_fb_reg;

            s6_h2_reg   <= (rsi_pkg::H2_W'(s5_hhh_reg) << (2*rsi_pkg::HL_W))
                         + (rsi_pkg::H2_W'(s5_hhl_reg) << (rsi_pkg::HL_W + 1))
                         + rsi_pkg::H2_W'(s5_hll_reg);
            s6_ac_reg   <= (rsi_pkg::AC_W'(s5_ahch_reg) << (rsi_pkg::AL_W + rsi_pkg::CL_W))
                         + (rsi_pkg::AC_W'(s5_ahcl_reg) << rsi_pkg::AL_W)
                         + (rsi_pkg::AC_W'(s5_alch_reg) << rsi_pkg::CL_W)
                         + rsi_pkg::AC_W'(s5_alcl_reg);
            s6_a_reg    <= s5_a_reg;
            s6_h_reg    <= s5_h_reg;
            s6_cneg_reg <= s5_cneg_reg;
            s6_za_reg   <= s5_za_reg;
            s6_fb_reg   <= s5_fb_reg;

            // The discriminant is four times h*h - a*c.
            s7_dq_reg   <= s6_cneg_reg ? rsi_pkg::D_W'(s6_h2_reg) + rsi_pkg::D_W'(s6_ac_reg)
                                       : rsi_pkg::D_W'(s6_h2_reg) - rsi_pkg::D_W'(s6_ac_reg);
            s7_a_reg    <= s6_a_reg;
            s7_h_reg    <= s6_h_reg;
            s7_za_reg   <= s6_za_reg;
            s7_fb_reg   <= s6_fb_reg;
        end
    end

    always_comb
    begin
        sq_rad              = rsi_pkg::RAD_W'({s7_dq_reg[rsi_pkg::D_W-2:0], 2'b00});
        sq_in_side.h        = s7_h_reg;
        sq_in_side.a        = s7_a_reg;
        sq_in_side.fallback = s7_fb_reg;
        sq_in_side.noroot   = s7_dq_reg[rsi_pkg::D_W-1];
        sq_in_side.zero_a   = s7_za_reg;
    end

    rsi_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s7_v_reg),
        .in_rad    (sq_rad),
        .in_side   (sq_in_side),
        .out_valid (sq_v),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign two_h    = rsi_pkg::NUM_W'($signed(sq_side.h)) <<< 1;
    // The nearer root counts as negative only when its truncated quotient is nonzero.
    assign near_neg = s9_sn_reg
                   && ({s9_mn_reg, {rsi_pkg::FRAC_BITS{1'b0}}} >= rsi_pkg::M_W'(s9_div_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_nn_reg  <= rsi_pkg::NUM_W'(-two_h - $signed(rsi_pkg::NUM_W'(sq_root)));
            s8_nf_reg  <= rsi_pkg::NUM_W'(-two_h + $signed(rsi_pkg::NUM_W'(sq_root)));
            s8_a_reg   <= sq_side.a;
            s8_nr_reg  <= sq_side.noroot;
            s8_za_reg  <= sq_side.zero_a;
            s8_fb_reg  <= sq_side.fallback;

            s9_mn_reg  <= rsi_pkg::NM_W'(s8_nn_reg[rsi_pkg::NUM_W-1] ? -s8_nn_reg : s8_nn_reg);
            s9_mf_reg  <= rsi_pkg::NM_W'(s8_nf_reg[rsi_pkg::NUM_W-1] ? -s8_nf_reg : s8_nf_reg);
            s9_sn_reg  <= s8_nn_reg[rsi_pkg::NUM_W-1];
            s9_sf_reg  <= s8_nf_reg[rsi_pkg::NUM_W-1];
            s9_div_reg <= {s8_a_reg, 1'b0};
            s9_nr_reg  <= s8_nr_reg;
            s9_za_reg  <= s8_za_reg;
            s9_fb_reg  <= s8_fb_reg;

            s10_m_reg   <= near_neg ? s9_mf_reg : s9_mn_reg;
            s10_neg_reg <= near_neg ? s9_sf_reg : s9_sn_reg;
            s10_div_reg <= s9_div_reg;
            s10_nr_reg  <= s9_nr_reg;
            s10_za_reg  <= s9_za_reg;
            s10_fb_reg  <= s9_fb_reg;
        end
    end

    always_comb
    begin
        dv_m                = {s10_m_reg, {rsi_pkg::FRAC_BITS{1'b0}}};
        dv_rem              = rsi_pkg::DV_W'(dv_m >> rsi_pkg::Q_W);
        dv_in_side.fallback = s10_fb_reg;
        dv_in_side.noroot   = s10_nr_reg;
        dv_in_side.zero_a   = s10_za_reg;
        dv_in_side.sel_neg  = s10_neg_reg;
        dv_in_side.ovf      = rsi_pkg::CMP_W'(dv_m)
                           >= rsi_pkg::CMP_W'({s10_div_reg, {rsi_pkg::Q_W{1'b0}}});
    end

    rsi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s10_v_reg),
        .in_rem    (dv_rem),
        .in_low    (dv_m[rsi_pkg::Q_W-1:0]),
        .in_div    (s10_div_reg),
        .in_side   (dv_in_side),
        .out_valid (dv_v),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    always_comb
    begin
        if (dv_side.noroot)
        begin
            out_dist_next = dv_side.fallback;
            out_st_next   = rsi_pkg::ST_NOROOT;
        end
        else if (dv_side.zero_a || dv_side.sel_neg || (!dv_side.ovf && dv_quo == '0))
        begin
            out_dist_next = rsi_pkg::FAR_DIST;
            out_st_next   = rsi_pkg::ST_BEHIND;
        end
        else if (dv_side.ovf)
        begin
            out_dist_next = rsi_pkg::MAX_DIST;
            out_st_next   = rsi_pkg::ST_HIT;
        end
        else
        begin
            out_dist_next = rsi_pkg::CW'(dv_quo);
            out_st_next   = rsi_pkg::ST_HIT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_dist_reg <= out_dist_next;
            out_st_reg   <= out_st_next;
        end
    end

    assign rsp.valid        = out_v_reg;
    assign rsp.hit_distance = out_dist_reg;
    assign rsp.hit_status   = out_st_reg;

endmodule

/* src/rsi_isqrt.sv */
// Pipelined floor square root, one result bit per stage.
module rsi_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [rsi_pkg::RAD_W-1:0]     in_rad,
    input  rsi_pkg::sq_side_t             in_side,
    output logic                          out_valid,
    output logic [rsi_pkg::SQ_W-1:0]      out_root,
    output rsi_pkg::sq_side_t             out_side
);

    logic                         vld_reg  [rsi_pkg::SQ_W];
    logic [rsi_pkg::SR_W-1:0]     rem_reg  [rsi_pkg::SQ_W];
    logic [rsi_pkg::SQ_W-1:0]     root_reg [rsi_pkg::SQ_W];
    logic [rsi_pkg::RAD_W-1:0]    rad_reg  [rsi_pkg::SQ_W];
    rsi_pkg::sq_side_t            side_reg [rsi_pkg::SQ_W];

    for (genvar i = 0; i < rsi_pkg::SQ_W; i++) begin : g_stage
        logic                      v_in;
        logic [rsi_pkg::SR_W-1:0]  rem_in;
        logic [rsi_pkg::SQ_W-1:0]  root_in;
        logic [rsi_pkg::RAD_W-1:0] rad_in;
        rsi_pkg::sq_side_t         side_in;
        logic [rsi_pkg::SR_W-1:0]  shifted;
        logic [rsi_pkg::SR_W-1:0]  trial;
        logic [rsi_pkg::SR_W-1:0]  rem_next;
        logic [rsi_pkg::SQ_W-1:0]  root_next;
        logic [rsi_pkg::RAD_W-1:0] rad_next;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_rad;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        // The partial remainder never exceeds twice the partial root, so the
        // two bits dropped by the shift are always zero.
        always_comb
        begin
            shifted  = {rem_in[rsi_pkg::SR_W-3:0], rad_in[rsi_pkg::RAD_W-1 -: 2]};
            trial    = {root_in, 2'b01};
            rad_next = {rad_in[rsi_pkg::RAD_W-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_in[rsi_pkg::SQ_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_in[rsi_pkg::SQ_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                rad_reg[i]  <= rad_next;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[rsi_pkg::SQ_W-1];
    assign out_root  = root_reg[rsi_pkg::SQ_W-1];
    assign out_side  = side_reg[rsi_pkg::SQ_W-1];

endmodule

/* src/rsi_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module rsi_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [rsi_pkg::DV_W-1:0]      in_rem,
    input  logic [rsi_pkg::Q_W-1:0]       in_low,
    input  logic [rsi_pkg::DV_W-1:0]      in_div,
    input  rsi_pkg::dv_side_t             in_side,
    output logic                          out_valid,
    output logic [rsi_pkg::Q_W-1:0]       out_quo,
    output rsi_pkg::dv_side_t             out_side
);

    logic                        vld_reg  [rsi_pkg::Q_W];
    logic [rsi_pkg::DV_W-1:0]    rem_reg  [rsi_pkg::Q_W];
    logic [rsi_pkg::Q_W-1:0]     low_reg  [rsi_pkg::Q_W];
    logic [rsi_pkg::Q_W-1:0]     quo_reg  [rsi_pkg::Q_W];
    logic [rsi_pkg::DV_W-1:0]    div_reg  [rsi_pkg::Q_W];
    rsi_pkg::dv_side_t           side_reg [rsi_pkg::Q_W];

    for (genvar i = 0; i < rsi_pkg::Q_W; i++) begin : g_stage
        logic                      v_in;
        logic [rsi_pkg::DV_W-1:0]  rem_in;
        logic [rsi_pkg::Q_W-1:0]   low_in;
        logic [rsi_pkg::Q_W-1:0]   quo_in;
        logic [rsi_pkg::DV_W-1:0]  div_in;
        rsi_pkg::dv_side_t         side_in;
        logic [rsi_pkg::DV_W:0]    part;
        logic                      ge;
        logic [rsi_pkg::DV_W-1:0]  rem_next;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_rem;
            assign low_in  = in_low;
            assign quo_in  = '0;
            assign div_in  = in_div;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign low_in  = low_reg[i-1];
            assign quo_in  = quo_reg[i-1];
            assign div_in  = div_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        always_comb
        begin
            part     = {rem_in, low_in[rsi_pkg::Q_W-1]};
            ge       = part >= {1'b0, div_in};
            rem_next = ge ? rsi_pkg::DV_W'(part - {1'b0, div_in})
                          : rsi_pkg::DV_W'(part);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                low_reg[i]  <= {low_in[rsi_pkg::Q_W-2:0], 1'b0};
                quo_reg[i]  <= {quo_in[rsi_pkg::Q_W-2:0], ge};
                div_reg[i]  <= div_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[rsi_pkg::Q_W-1];
    assign out_quo   = quo_reg[rsi_pkg::Q_W-1];
    assign out_side  = side_reg[rsi_pkg::Q_W-1];

endmodule

/* tb/tb.sv */
// Self-checking testbench for ray_sphere_intersect: directed table, random rays, exact predictor.
`timescale 1ns / 100ps

module tb;

    localparam int W          = 256;
    localparam int CW         = rsi_pkg::CW;
    localparam int N_RANDOM   = 2000;
    localparam int CYCLE_CAP  = 600000;
    localparam int DRAIN_WAIT = 3 * rsi_pkg::COORD_WIDTH + 40;

    typedef struct {
        logic signed [CW-1:0] ox, oy, oz, dx, dy, dz, cx, cy, cz;
        logic        [CW-2:0] radius;
        logic signed [CW-1:0] fallback;
    } ray_beat_t;

    typedef struct {
        logic signed [CW-1:0] distance;
        logic        [1:0]    status;
    } hit_beat_t;

    typedef struct {
        ray_beat_t ray;
        bit        typed;
        hit_beat_t want;
    } ray_row_t;

    logic clk;
    logic rst_n;

    rsi_req_if req_ch ();
    rsi_rsp_if rsp_ch ();

    ray_sphere_intersect i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    hit_beat_t pending_hits[$];
    ray_row_t  ray_table[$];
    ray_row_t  typed_rows[$];
    int        mismatches;
    int        cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Floor square root of a non-negative wide value.
    function automatic logic [W-1:0] floor_sqrt(logic [W-1:0] n);
        logic [W-1:0] root;
        logic [W-1:0] probe;
        logic [W-1:0] trial;
        root  = '0;
        probe = {2'b01, {(W - 2){1'b0}}};
        while (probe != 0)
        begin
            trial = root + probe;
            if (n >= trial)
            begin
                n    = n - trial;
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic hit_beat_t nearest_hit(ray_beat_t r);
        logic signed [W-1:0] dvx, dvy, dvz, ocx, ocy, ocz, rr;
        logic signed [W-1:0] a, h, c, b, disc, s, twoa, near_t, far_t, t, hi;
        hit_beat_t res;
        dvx = r.dx;
        dvy = r.dy;
        dvz = r.dz;
        ocx = W'(r.ox) - W'(r.cx);
        ocy = W'(r.oy) - W'(r.cy);
        ocz = W'(r.oz) - W'(r.cz);
        rr  = $signed({{(W - CW + 1){1'b0}}, r.radius});
        a    = dvx * dvx + dvy * dvy + dvz * dvz;
        h    = dvx * ocx + dvy * ocy + dvz * ocz;
        c    = ocx * ocx + ocy * ocy + ocz * ocz - rr * rr;
        b    = h + h;
        disc = b * b - ((a * c) <<< 2);
        hi   = $signed({{(W - CW){1'b0}}, rsi_pkg::MAX_DIST});
        if (disc < 0)
        begin
            res.distance = r.fallback;
            res.status   = rsi_pkg::ST_NOROOT;
            return res;
        end
        if (a != 0)
        begin
            s      = $signed(floor_sqrt(disc));
            twoa   = a + a;
            // Signed division truncates toward zero, as the roots require.
            near_t = ((-b - s) <<< rsi_pkg::FRAC_BITS) / twoa;
            far_t  = ((-b + s) <<< rsi_pkg::FRAC_BITS) / twoa;
            t      = (near_t < 0) ? far_t : near_t;
            if (t > 0)
            begin
                res.distance = (t >= hi) ? rsi_pkg::MAX_DIST : t[CW-1:0];
                res.status   = rsi_pkg::ST_HIT;
                return res;
            end
        end
        res.distance = rsi_pkg::FAR_DIST;
        res.status   = rsi_pkg::ST_BEHIND;
        return res;
    endfunction

    task automatic add_row(input logic signed [CW-1:0] ox, oy, oz, dx, dy, dz, cx, cy, cz,
                           input logic [CW-2:0] radius, input logic signed [CW-1:0] fallback,
                           input bit typed, input logic signed [CW-1:0] distance,
                           input logic [1:0] status);
        ray_row_t row;
        row.ray = '{ox, oy, oz, dx, dy, dz, cx, cy, cz, radius, fallback};
        row.typed         = typed;
        row.want.distance = distance;
        row.want.status   = status;
        ray_table.push_back(row);
    endtask

    function automatic logic signed [CW-1:0] any_word();
        return $urandom;
    endfunction

    // Small coordinates around a unit scale make hits and misses both common.
    function automatic logic signed [CW-1:0] scene_coord(int span);
        return $signed(CW'($urandom_range(2 * span, 0))) - span;
    endfunction

    function automatic ray_beat_t random_ray();
        ray_beat_t r;
        int span;
        int mode;
        mode = $urandom_range(9, 0);
        if (mode < 6)
        begin
            span = 1 << $urandom_range(24, 12);
            r.ox = scene_coord(span);
            r.oy = scene_coord(span);
            r.oz = scene_coord(span);
            r.dx = scene_coord(span);
            r.dy = scene_coord(span);
            r.dz = scene_coord(span);
            r.cx = scene_coord(span);
            r.cy = scene_coord(span);
            r.cz = scene_coord(span);
            r.radius = (CW - 1)'($urandom_range(span, 0));
        end
        else
        begin
            r.ox = any_word();
            r.oy = any_word();
            r.oz = any_word();
            r.dx = any_word();
            r.dy = any_word();
            r.dz = any_word();
            r.cx = any_word();
            r.cy = any_word();
            r.cz = any_word();
            r.radius = (CW - 1)'($urandom);
            if (mode == 9)
            begin
                r.dx = '0;
                r.dy = '0;
                r.dz = '0;
            end
        end
        r.fallback = any_word();
        return r;
    endfunction

    task automatic send_ray(input ray_row_t row);
        req_ch.valid             = 1'b1;
        req_ch.origin_x          = row.ray.ox;
        req_ch.origin_y          = row.ray.oy;
        req_ch.origin_z          = row.ray.oz;
        req_ch.dir_x             = row.ray.dx;
        req_ch.dir_y             = row.ray.dy;
        req_ch.dir_z             = row.ray.dz;
        req_ch.center_x          = row.ray.cx;
        req_ch.center_y          = row.ray.cy;
        req_ch.center_z          = row.ray.cz;
        req_ch.sphere_radius     = row.ray.radius;
        req_ch.fallback_distance = row.ray.fallback;
        typed_rows.push_back(row);
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Expected results are queued when the request beat is taken.
    always @(posedge clk)
    begin
        hit_beat_t want;
        ray_row_t  row;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            row  = typed_rows.pop_front();
            want = nearest_hit(row.ray);
            if (row.typed && (want.distance !== row.want.distance
                              || want.status !== row.want.status))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row disagrees with prediction: %0d/%0d vs %0d/%0d",
                             row.want.distance, row.want.status, want.distance, want.status);
            end
            pending_hits.push_back(want);
        end
    end

    always @(posedge clk)
    begin
        hit_beat_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response beat: dist %0d status %0d",
                             rsp_ch.hit_distance, rsp_ch.hit_status);
            end
            else
            begin
                want = pending_hits.pop_front();
                if (rsp_ch.hit_distance !== want.distance || rsp_ch.hit_status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: dist exp %0d got %0d, status exp %0d got %0d",
                                 want.distance, rsp_ch.hit_distance, want.status,
                                 rsp_ch.hit_status);
                end
            end
        end
    end

    // The receiver cycles through always-ready, random, and mostly-stalled stretches.
    always @(negedge clk)
    begin
        int mode;
        mode = (cycles / 97) % 3;
        if (mode == 0)
            rsp_ch.ready <= 1'b1;
        else if (mode == 1)
            rsp_ch.ready <= $urandom_range(1, 0);
        else
            rsp_ch.ready <= ($urandom_range(7, 0) == 0);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("ray_sphere_intersect verification failed");
            $finish;
        end
    end

    initial
    begin
        ray_row_t row;
        int burst;
        int gap;
        mismatches = 0;
        cycles     = 0;
        rst_n      = 1'b0;
        rsp_ch.ready = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.origin_x = '0;
        req_ch.origin_y = '0;
        req_ch.origin_z = '0;
        req_ch.dir_x = '0;
        req_ch.dir_y = '0;
        req_ch.dir_z = '0;
        req_ch.center_x = '0;
        req_ch.center_y = '0;
        req_ch.center_z = '0;
        req_ch.sphere_radius = '0;
        req_ch.fallback_distance = '0;

        // Hit straight ahead at distance 4.
        add_row(0, 0, 0, 0, 0, 32'sh10000, 0, 0, 32'sh50000, 31'h10000, 7, 1, 32'sh40000,
                rsi_pkg::ST_HIT);
        // Sphere behind the ray.
        add_row(0, 0, 0, 0, 0, 32'sh10000, 0, 0, -32'sh50000, 31'h10000, 7, 1,
                rsi_pkg::FAR_DIST, rsi_pkg::ST_BEHIND);
        // Miss: the fallback comes back unchanged.
        add_row(0, 32'sh0a0000, 0, 32'sh10000, 0, 0, 0, 0, 0, 31'h10000, -32'sh1234, 1,
                -32'sh1234, rsi_pkg::ST_NOROOT);
        // Zero direction never divides.
        add_row(5, 6, 7, 0, 0, 0, 1, 2, 3, 31'h7fffffff, 99, 1, rsi_pkg::FAR_DIST,
                rsi_pkg::ST_BEHIND);
        // A tiny direction toward a far sphere saturates the distance.
        add_row(0, 0, 0, 1, 0, 0, 32'sh40000000, 0, 0, 31'h10000, 0, 1, rsi_pkg::MAX_DIST,
                rsi_pkg::ST_HIT);
        // Origin inside the sphere picks the far root.
        add_row(0, 0, 0, 32'sh10000, 0, 0, 0, 0, 0, 31'h20000, 0, 1, 32'sh20000,
                rsi_pkg::ST_HIT);
        // Tangent ray, zero discriminant.
        add_row(0, 32'sh10000, 0, 32'sh10000, 0, 0, 32'sh30000, 0, 0, 31'h10000, 0, 0, 0, 0);
        // Field extremes.
        add_row(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 31'h7fffffff,
                32'h80000000, 0, 0, 0);
        add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 32'h7fffffff,
                0, 0, 0);
        add_row(-1, -1, -1, -1, -1, -1, 0, 0, 0, 31'h7fffffff, -1, 0, 0, 0);
        add_row(0, 0, 0, 32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 0, 1, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, rsi_pkg::FAR_DIST, rsi_pkg::ST_BEHIND);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (ray_table[i])
            send_ray(ray_table[i]);

        for (int n = 0; n < N_RANDOM; )
        begin
            burst = $urandom_range(24, 1);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
            begin
                row.ray   = random_ray();
                row.typed = 0;
                row.want  = '{0, 0};
                send_ray(row);
                if (n == N_RANDOM / 2)
                begin
                    req_ch.valid = 1'b0;
                    while (pending_hits.size() != 0)
                        @(negedge clk);
                end
            end
            req_ch.valid = 1'b0;
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(10, 1);
            repeat (gap) @(negedge clk);
        end
        req_ch.valid = 1'b0;

        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && pending_hits.size() == 0)
            $display("ray_sphere_intersect verification clean");
        else
            $display("ray_sphere_intersect verification failed");
        $finish;
    end

endmodule

/* filelist.f */
src/rsi_pkg.sv
src/rsi_if.sv
src/rsi_isqrt.sv
src/rsi_div.sv
src/ray_sphere_intersect.sv
tb/tb.sv
